FILE: rtl/core/wmtm_pkg.sv
// ----------------------------------------------------------------------------
// wmtm_pkg
// Shared types and constants of the Wi-Fi management threat monitor.
// ----------------------------------------------------------------------------
package wmtm_pkg;

	localparam int MAC_W    = 48;
	localparam int LEN_W    = 12;
	localparam int FC_W     = 8;
	localparam int PERIOD_W = 20;
	localparam int LIMIT_W  = 16;
	localparam int SCORE_W  = 20;
	localparam int CFG_W    = 48;
	localparam int CFG_IDX_W = 3;
	localparam int SHOWN_W  = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_OWN_MAC      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLEAR_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCORE_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALERT_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAUTION      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DANGER       = 3'd5;

	// Configuration reset values.
	localparam logic [MAC_W-1:0]    RST_OWN_MAC      = '0;
	localparam logic [PERIOD_W-1:0] RST_CLEAR_PERIOD = 20'd30000;
	localparam logic [LIMIT_W-1:0]  RST_SCORE_LIMIT  = 16'd30;
	localparam logic [LIMIT_W-1:0]  RST_ALERT_LIMIT  = 16'd50;
	localparam logic [SCORE_W-1:0]  RST_CAUTION      = 20'd5;
	localparam logic [SCORE_W-1:0]  RST_DANGER       = 20'd15;

	// Management subtypes of interest.
	localparam logic [3:0] SUBTYPE_DEAUTH    = 4'hC;
	localparam logic [3:0] SUBTYPE_DISASSOC  = 4'hA;
	localparam logic [3:0] SUBTYPE_PROBE_RSP = 4'h5;
	localparam logic [3:0] SUBTYPE_PROBE_REQ = 4'h4;

	localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 12'd24;

	// Score weights.
	localparam int DEAUTH_WEIGHT   = 10;
	localparam int DIRECTED_WEIGHT = 8;
	localparam int FLOOD_WEIGHT    = 5;

	typedef enum logic [1:0] {
		ALERT_NONE     = 2'd0,
		ALERT_DEAUTH   = 2'd1,
		ALERT_FLOOD    = 2'd2,
		ALERT_DIRECTED = 2'd3
	} alert_t;

	typedef enum logic [1:0] {
		LEVEL_CLEAR   = 2'd0,
		LEVEL_CAUTION = 2'd1,
		LEVEL_DANGER  = 2'd2
	} level_t;

	typedef struct packed {
		logic                mode;
		logic                is_management;
		logic [LEN_W-1:0]    frame_length;
		logic [FC_W-1:0]     frame_control_low;
		logic [MAC_W-1:0]    first_address;
		logic [MAC_W-1:0]    third_address;
	} item_t;

	typedef struct packed {
		logic [MAC_W-1:0]    own_mac;
		logic [PERIOD_W-1:0] flood_clear_period;
		logic [LIMIT_W-1:0]  flood_score_limit;
		logic [LIMIT_W-1:0]  flood_alert_limit;
		logic [SCORE_W-1:0]  caution_score;
		logic [SCORE_W-1:0]  danger_score;
	} cfg_t;

	// Status that travels from the update stage to the scoring stage.
	typedef struct packed {
		logic   flood_over;
		logic   cleared;
		alert_t alert;
	} upd_flags_t;

endpackage

FILE: rtl/core/wmtm_update.sv
// ----------------------------------------------------------------------------
// wmtm_update
// Classifies one item and computes the next counter, alert and timer state.
// ----------------------------------------------------------------------------
module wmtm_update #(
	parameter int COUNT_BITS = 16
) (
	input  wmtm_pkg::item_t           item,
	input  wmtm_pkg::cfg_t            cfg,
	input  logic [COUNT_BITS-1:0]     deauth_cur,
	input  logic [COUNT_BITS-1:0]     flood_cur,
	input  logic [COUNT_BITS-1:0]     directed_cur,
	input  wmtm_pkg::alert_t          alert_cur,
	input  logic [wmtm_pkg::PERIOD_W-1:0] ms_cur,
	output logic [COUNT_BITS-1:0]     deauth_nxt,
	output logic [COUNT_BITS-1:0]     flood_nxt,
	output logic [COUNT_BITS-1:0]     directed_nxt,
	output logic [wmtm_pkg::PERIOD_W-1:0] ms_nxt,
	output wmtm_pkg::upd_flags_t      flags
);
	import wmtm_pkg::*;

	localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [3:0]            subtype;
	logic                  frame_ok;
	logic                  a1_hit;
	logic                  a3_hit;
	logic [PERIOD_W-1:0]   ms_inc;
	logic                  clear_now;
	logic [COUNT_BITS-1:0] deauth_bump;
	logic [COUNT_BITS-1:0] flood_bump;
	logic [COUNT_BITS-1:0] directed_bump;
	alert_t                alert_nxt;

	assign subtype  = item.frame_control_low[7:4];
	assign frame_ok = !item.mode && item.is_management && (item.frame_length >= MIN_FRAME_LEN);
	assign a1_hit   = (item.first_address == cfg.own_mac);
	assign a3_hit   = (item.third_address == cfg.own_mac);

	// The millisecond timer stops at its top value.
	assign ms_inc    = (ms_cur != '1) ? ms_cur + 1'b1 : ms_cur;
	assign clear_now = (ms_inc > cfg.flood_clear_period);

	assign deauth_bump   = (deauth_cur != COUNT_MAX) ? deauth_cur + 1'b1 : deauth_cur;
	assign flood_bump    = (flood_cur != COUNT_MAX) ? flood_cur + 1'b1 : flood_cur;
	assign directed_bump = (directed_cur != COUNT_MAX) ? directed_cur + 1'b1 : directed_cur;

	always_comb begin
		deauth_nxt   = deauth_cur;
		flood_nxt    = flood_cur;
		directed_nxt = directed_cur;
		ms_nxt       = ms_cur;
		alert_nxt    = alert_cur;
		flags.cleared = 1'b0;
		if (item.mode) begin
			ms_nxt = ms_inc;
			if (clear_now) begin
				flood_nxt     = '0;
				ms_nxt        = '0;
				flags.cleared = 1'b1;
			end
		end else if (frame_ok) begin
			if ((subtype == SUBTYPE_DEAUTH) || (subtype == SUBTYPE_DISASSOC)) begin
				if (a1_hit) begin
					deauth_nxt = deauth_bump;
					alert_nxt  = ALERT_DEAUTH;
				end
			end else if (subtype == SUBTYPE_PROBE_RSP) begin
				flood_nxt = flood_bump;
				if (CMP_W'(flood_bump) > CMP_W'(cfg.flood_alert_limit)) begin
					alert_nxt = ALERT_FLOOD;
				end
			end else if (subtype == SUBTYPE_PROBE_REQ) begin
				if (a1_hit || a3_hit) begin
					directed_nxt = directed_bump;
					alert_nxt    = ALERT_DIRECTED;
				end
			end
		end
		flags.alert      = alert_nxt;
		flags.flood_over = (CMP_W'(flood_nxt) > CMP_W'(cfg.flood_score_limit));
	end

endmodule

FILE: rtl/core/wmtm_level.sv
// ----------------------------------------------------------------------------
// wmtm_level
// Weighted threat score and its mapping onto clear, caution and danger.
// ----------------------------------------------------------------------------
module wmtm_level #(
	parameter int COUNT_BITS = 16
) (
	input  logic [COUNT_BITS-1:0] deauth,
	input  logic [COUNT_BITS-1:0] directed,
	input  logic                  flood_over,
	input  wmtm_pkg::cfg_t        cfg,
	output wmtm_pkg::level_t      level
);
	import wmtm_pkg::*;

	// Ten and eight times a full counter plus five fits in five more bits.
	localparam int SW = (COUNT_BITS + 5 > SCORE_W) ? COUNT_BITS + 5 : SCORE_W;

	logic [SW-1:0] score;

	assign score = SW'(deauth) * SW'(DEAUTH_WEIGHT)
	             + SW'(directed) * SW'(DIRECTED_WEIGHT)
	             + (flood_over ? SW'(FLOOD_WEIGHT) : '0);

	always_comb begin
		if (score >= SW'(cfg.danger_score)) begin
			level = LEVEL_DANGER;
		end else if (score >= SW'(cfg.caution_score)) begin
			level = LEVEL_CAUTION;
		end else begin
			level = LEVEL_CLEAR;
		end
	end

endmodule

FILE: rtl/core/wifi_mgmt_threat_monitor_unit.sv
// ----------------------------------------------------------------------------
// wifi_mgmt_threat_monitor_unit
// Watches captured 802.11 management headers and millisecond ticks and
// reports a running threat level with its counters.
// ----------------------------------------------------------------------------
// The block takes one request per clock on its input stream while the output
// side does not stall, and returns one result per request, in order. Each
// request passes through the input register, the stage-two registers and the
// output register. A request is either a frame header summary
// (tuser low) or a one-millisecond tick (tuser high). The first stage
// registers the request, the second classifies it and updates the saturating
// deauth, probe-flood and directed-probe counters, the last-alert code and the
// millisecond timer, and the third forms the weighted score (ten per deauth,
// eight per directed probe, five while the flood count is above its limit) and
// registers the level. Each result shows the state after its own request.
// Every stage is a register with its own valid bit, so a stall on the output
// only backs up as far as it must; without an output stall, throughput stays
// at one request per cycle. The configuration registers are written through a
// plain write port and must only change while no request is in flight.
// ----------------------------------------------------------------------------
module wifi_mgmt_threat_monitor_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [wmtm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wmtm_pkg::CFG_W-1:0]        cfg_data,
	// Input stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata from bit 0: is_management, frame_length[11:0],
	// frame_control_low[7:0], first_address[47:0], third_address[47:0], zero fill.
	input  logic [119:0]                      s_axis_tdata,
	// tuser: mode (0 frame, 1 tick).
	input  logic                              s_axis_tuser,
	// Output stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata from bit 0: threat_level[1:0], deauths_seen[15:0], flood_seen[15:0],
	// probes_at_us[15:0], alert_code[1:0], flood_cleared, zero fill.
	output logic [55:0]                       m_axis_tdata
);
	import wmtm_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_mac            <= RST_OWN_MAC;
			cfg_q.flood_clear_period <= RST_CLEAR_PERIOD;
			cfg_q.flood_score_limit  <= RST_SCORE_LIMIT;
			cfg_q.flood_alert_limit  <= RST_ALERT_LIMIT;
			cfg_q.caution_score      <= RST_CAUTION;
			cfg_q.danger_score       <= RST_DANGER;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_OWN_MAC:      cfg_q.own_mac            <= cfg_data[MAC_W-1:0];
				CFG_IDX_CLEAR_PERIOD: cfg_q.flood_clear_period <= cfg_data[PERIOD_W-1:0];
				CFG_IDX_SCORE_LIMIT:  cfg_q.flood_score_limit  <= cfg_data[LIMIT_W-1:0];
				CFG_IDX_ALERT_LIMIT:  cfg_q.flood_alert_limit  <= cfg_data[LIMIT_W-1:0];
				CFG_IDX_CAUTION:      cfg_q.caution_score      <= cfg_data[SCORE_W-1:0];
				CFG_IDX_DANGER:       cfg_q.danger_score       <= cfg_data[SCORE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline handshake. Each stage loads when it is empty or when the stage
	// behind it is taking its contents in the same cycle.
	logic  valid_s1;
	logic  valid_s2;
	logic  out_valid_q;
	logic  load_out;
	logic  ready_s2;
	logic  adv_s1;
	logic  adv_s2;
	logic  in_take;

	assign load_out      = !out_valid_q || m_axis_tready;
	assign ready_s2      = !valid_s2 || load_out;
	assign s_axis_tready = !valid_s1 || ready_s2;
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign adv_s1        = valid_s1 && ready_s2;
	assign adv_s2        = valid_s2 && load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Stage 1: input register.
	item_t item_in;
	item_t item_s1;

	assign item_in.mode              = s_axis_tuser;
	assign item_in.is_management     = s_axis_tdata[0];
	assign item_in.frame_length      = s_axis_tdata[12:1];
	assign item_in.frame_control_low = s_axis_tdata[20:13];
	assign item_in.first_address     = s_axis_tdata[68:21];
	assign item_in.third_address     = s_axis_tdata[116:69];

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
	end

	// Stage 2: classification and state update. The running state is written
	// as the request moves on, and a copy of it goes with the request.
	logic [COUNT_BITS-1:0] deauth_q;
	logic [COUNT_BITS-1:0] flood_q;
	logic [COUNT_BITS-1:0] directed_q;
	alert_t                alert_q;
	logic [PERIOD_W-1:0]   ms_q;

	logic [COUNT_BITS-1:0] deauth_nxt;
	logic [COUNT_BITS-1:0] flood_nxt;
	logic [COUNT_BITS-1:0] directed_nxt;
	logic [PERIOD_W-1:0]   ms_nxt;
	upd_flags_t            flags_nxt;

	wmtm_update #(
		.COUNT_BITS(COUNT_BITS)
	) u_update (
		.item         (item_s1),
		.cfg          (cfg_q),
		.deauth_cur   (deauth_q),
		.flood_cur    (flood_q),
		.directed_cur (directed_q),
		.alert_cur    (alert_q),
		.ms_cur       (ms_q),
		.deauth_nxt   (deauth_nxt),
		.flood_nxt    (flood_nxt),
		.directed_nxt (directed_nxt),
		.ms_nxt       (ms_nxt),
		.flags        (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deauth_q   <= '0;
			flood_q    <= '0;
			directed_q <= '0;
			alert_q    <= ALERT_NONE;
			ms_q       <= '0;
		end else if (adv_s1) begin
			deauth_q   <= deauth_nxt;
			flood_q    <= flood_nxt;
			directed_q <= directed_nxt;
			alert_q    <= flags_nxt.alert;
			ms_q       <= ms_nxt;
		end
	end

	logic [COUNT_BITS-1:0] deauth_s2;
	logic [COUNT_BITS-1:0] flood_s2;
	logic [COUNT_BITS-1:0] directed_s2;
	upd_flags_t            flags_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			deauth_s2   <= deauth_nxt;
			flood_s2    <= flood_nxt;
			directed_s2 <= directed_nxt;
			flags_s2    <= flags_nxt;
		end
	end

	// Stage 3: score, level and the output register.
	level_t level_s2;

	wmtm_level #(
		.COUNT_BITS(COUNT_BITS)
	) u_level (
		.deauth     (deauth_s2),
		.directed   (directed_s2),
		.flood_over (flags_s2.flood_over),
		.cfg        (cfg_q),
		.level      (level_s2)
	);

	// The reported counts are the low sixteen bits, zero-extended for narrow
	// counters.
	logic [COUNT_BITS+SHOWN_W-1:0] deauth_ext;
	logic [COUNT_BITS+SHOWN_W-1:0] flood_ext;
	logic [COUNT_BITS+SHOWN_W-1:0] directed_ext;
	logic [55:0]                   out_data_q;

	assign deauth_ext   = {{SHOWN_W{1'b0}}, deauth_s2};
	assign flood_ext    = {{SHOWN_W{1'b0}}, flood_s2};
	assign directed_ext = {{SHOWN_W{1'b0}}, directed_s2};

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_data_q <= {3'b000, flags_s2.cleared, flags_s2.alert,
				directed_ext[SHOWN_W-1:0], flood_ext[SHOWN_W-1:0],
				deauth_ext[SHOWN_W-1:0], level_s2};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A tick that cleared the flood count must report a zero flood count.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[52]) |-> (m_axis_tdata[33:18] == 16'd0))
		else $error("flood_cleared reported with a nonzero flood count");

	// The deauth and directed-probe counters never go down.
	a_counts_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((deauth_q >= $past(deauth_q)) && (directed_q >= $past(directed_q))))
		else $error("deauth or directed-probe counter decreased");

	// A request held in the input stage while stalled keeps its contents.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled input stage lost or changed its request");

endmodule
